@@ rtl/bba_pkg.sv @@
// Shared types and constants of the bitmap block allocator.
// Used by every module under rtl; depends on nothing.
package bba_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int MAP_AW     = $clog2(MAX_BLOCKS);
	localparam int SWEEP_W    = MAP_AW + 1;
	localparam int CNT_W      = 11;
	localparam int REQ_W      = 16;
	localparam int BS_W       = 8;
	localparam int BN_W       = 10;
	localparam int DIVD_W     = REQ_W + 1;
	localparam int DCNT_W     = $clog2(DIVD_W + 1);
	localparam int SLOT_W     = BS_W - 2;
	localparam int TOTAL_W    = SLOT_W + 1;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'd1;

	localparam logic [CNT_W-1:0] POOL_SIZE_RST  = 11'd1024;
	localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = 8'd64;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_MANY = 2'd1,
		ST_NO_SPACE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_RECOUNT,
		S_IDLE,
		S_DIVIDE,
		S_CHECK,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic    clear_run;
		logic    recount_start;
		logic    recount_run;
		logic    accept;
		logic    scan_start;
		logic    scan_run;
		logic    emit_err;
		status_t err_code;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic recount_done;
		logic recount_pend;
		logic div_done;
		logic reject_size;
		logic reject_free;
		logic scan_done;
	} sts_t;

endpackage

@@ rtl/bba_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on bba_pkg for widths.
module bba_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bba_pkg::DIVD_W-1:0]    dividend,
	input  logic [bba_pkg::BS_W-1:0]      divisor,
	output logic [bba_pkg::DIVD_W-1:0]    quotient,
	output logic                          done
);

	logic [bba_pkg::DIVD_W-1:0] num_q;
	logic [bba_pkg::BS_W-1:0]   rem_q;
	logic [bba_pkg::DCNT_W-1:0] cnt_q;
	logic                       done_q;
	logic [bba_pkg::BS_W:0]     trial;
	logic [bba_pkg::BS_W:0]     diff;
	logic                       ge;

	assign trial = {rem_q, num_q[bba_pkg::DIVD_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= bba_pkg::DCNT_W'(bba_pkg::DIVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bba_pkg::DCNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			// shift the quotient bit in behind the dividend
			num_q <= {num_q[bba_pkg::DIVD_W-2:0], ge};
			rem_q <= ge ? diff[bba_pkg::BS_W-1:0] : trial[bba_pkg::BS_W-1:0];
		end
	end

	assign quotient = num_q;
	assign done     = done_q;

endmodule

@@ rtl/bba_datapath.sv @@
// Datapath: configuration registers, used-block bitmap memory, sweep counter,
// free counter and result registers. Depends on bba_pkg and bba_div.
module bba_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bba_pkg::cmd_t                    cmd,
	output bba_pkg::sts_t                    sts,
	input  logic [bba_pkg::REQ_W-1:0]        request_bytes,
	input  logic                             cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bba_pkg::CNT_W-1:0]        cfg_wdata,
	output logic                             result_valid,
	output logic [bba_pkg::BN_W-1:0]         block_number,
	output logic                             is_index_block,
	output logic [1:0]                       status,
	output logic                             last,
	output logic [bba_pkg::CNT_W-1:0]        free_count
);

	logic [bba_pkg::CNT_W-1:0]   pool_size_q;
	logic [bba_pkg::BS_W-1:0]    block_size_q;
	logic [bba_pkg::CNT_W-1:0]   eff_count;
	logic                        pend_q;

	logic                        used_map [bba_pkg::MAX_BLOCKS];
	logic                        map_we;
	logic [bba_pkg::MAP_AW-1:0]  map_waddr;
	logic                        map_wdata;

	logic [bba_pkg::SWEEP_W-1:0] sweep_q;
	logic                        valid_s1;
	logic [bba_pkg::MAP_AW-1:0]  addr_s1;
	logic                        rd_bit_s1;
	logic                        in_range_s1;

	logic [bba_pkg::CNT_W-1:0]   zcount_q;
	logic [bba_pkg::CNT_W-1:0]   free_q;
	logic                        req_nz_q;
	logic [bba_pkg::TOTAL_W-1:0] total_q;
	logic [bba_pkg::TOTAL_W-1:0] found_q;

	logic [bba_pkg::DIVD_W-1:0]  dividend;
	logic [bba_pkg::DIVD_W-1:0]  quotient;
	logic                        div_done;
	logic [bba_pkg::SLOT_W-1:0]  slots;
	logic                        bs_zero;
	logic [bba_pkg::TOTAL_W-1:0] total;
	logic                        pick;
	logic                        pick_last;
	logic                        sweep_end;

	logic                        res_valid_q;
	logic [bba_pkg::BN_W-1:0]    res_block_q;
	logic                        res_index_q;
	bba_pkg::status_t            res_status_q;
	logic                        res_last_q;
	logic [bba_pkg::CNT_W-1:0]   res_free_q;

	assign eff_count = (pool_size_q > bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS)) ?
		bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS) : pool_size_q;

	// configuration and recount request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q  <= bba_pkg::POOL_SIZE_RST;
			block_size_q <= bba_pkg::BLOCK_SIZE_RST;
			pend_q       <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == bba_pkg::REG_POOL_SIZE) begin
				pool_size_q <= cfg_wdata;
				pend_q      <= 1'b1;
			end else if (cmd.recount_start || (cmd.clear_run && sweep_end)) begin
				pend_q <= 1'b0;
			end
			if (cfg_we && cfg_index == bba_pkg::REG_BLOCK_SIZE)
				block_size_q <= cfg_wdata[bba_pkg::BS_W-1:0];
		end
	end

	// divider: ceiling of request over block size
	assign bs_zero  = block_size_q == '0;
	assign dividend = {1'b0, request_bytes} + bba_pkg::DIVD_W'(block_size_q)
		- bba_pkg::DIVD_W'(1);

	bba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.accept),
		.dividend (dividend),
		.divisor  (block_size_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign slots = block_size_q[bba_pkg::BS_W-1:2];
	assign total = bs_zero ? bba_pkg::TOTAL_W'(1) :
		{1'b0, quotient[bba_pkg::SLOT_W-1:0]} + bba_pkg::TOTAL_W'(1);

	// bitmap memory
	assign sweep_end   = sweep_q[bba_pkg::MAP_AW];
	assign in_range_s1 = bba_pkg::CNT_W'(addr_s1) < eff_count;
	assign pick        = cmd.scan_run && valid_s1 && !rd_bit_s1 && in_range_s1;
	assign pick_last   = found_q == total_q - bba_pkg::TOTAL_W'(1);

	always_comb begin
		map_we    = 1'b0;
		map_waddr = sweep_q[bba_pkg::MAP_AW-1:0];
		map_wdata = 1'b0;
		if (cmd.clear_run && !sweep_end) begin
			map_we = 1'b1;
		end else if (pick) begin
			map_we    = 1'b1;
			map_waddr = addr_s1;
			map_wdata = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we)
			used_map[map_waddr] <= map_wdata;
		rd_bit_s1 <= used_map[sweep_q[bba_pkg::MAP_AW-1:0]];
		addr_s1   <= sweep_q[bba_pkg::MAP_AW-1:0];
	end

	// sweep, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q  <= '0;
			valid_s1 <= 1'b0;
			zcount_q <= '0;
			free_q   <= bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS);
			req_nz_q <= 1'b0;
			total_q  <= '0;
			found_q  <= '0;
		end else begin
			valid_s1 <= 1'b0;
			if (cmd.accept)
				req_nz_q <= request_bytes != '0;
			if (cmd.clear_run) begin
				if (sweep_end)
					free_q <= eff_count;
				else
					sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.recount_start || cmd.scan_start) begin
				sweep_q  <= '0;
				zcount_q <= '0;
				found_q  <= '0;
			end
			if (cmd.scan_start) begin
				total_q <= total;
				free_q  <= free_q - bba_pkg::CNT_W'(total);
			end
			if (cmd.recount_run || cmd.scan_run) begin
				valid_s1 <= !sweep_end;
				if (!sweep_end)
					sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.recount_run) begin
				if (valid_s1 && !rd_bit_s1 && in_range_s1)
					zcount_q <= zcount_q + 1'b1;
				if (sweep_end && !valid_s1)
					free_q <= zcount_q;
			end
			if (pick)
				found_q <= found_q + 1'b1;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else
			res_valid_q <= cmd.emit_err || pick;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			res_block_q  <= '0;
			res_index_q  <= 1'b0;
			res_status_q <= cmd.err_code;
			res_last_q   <= 1'b1;
			res_free_q   <= free_q;
		end else if (pick) begin
			res_block_q  <= bba_pkg::BN_W'(addr_s1);
			res_index_q  <= found_q == '0;
			res_status_q <= bba_pkg::ST_OK;
			res_last_q   <= pick_last;
			res_free_q   <= free_q;
		end
	end

	assign result_valid   = res_valid_q;
	assign block_number   = res_block_q;
	assign is_index_block = res_index_q;
	assign status         = res_status_q;
	assign last           = res_last_q;
	assign free_count     = res_free_q;

	assign sts.clear_done   = sweep_end;
	assign sts.recount_done = sweep_end && !valid_s1;
	assign sts.recount_pend = pend_q;
	assign sts.div_done     = div_done;
	assign sts.reject_size  = bs_zero ? req_nz_q :
		(quotient > bba_pkg::DIVD_W'(slots));
	assign sts.reject_free  = bba_pkg::CNT_W'(total) > free_q;
	assign sts.scan_done    = pick && pick_last;

endmodule

@@ rtl/bba_ctrl.sv @@
// Controller state machine: clearing pass, recount, divide, check, scan.
// Depends on bba_pkg for the state, command and status types.
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd,
	output logic          busy
);

	bba_pkg::state_t state_q;
	bba_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bba_pkg::S_CLEAR;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != bba_pkg::S_IDLE) || sts.recount_pend;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.err_code = bba_pkg::ST_OK;
		case (state_q)
			bba_pkg::S_CLEAR: begin
				cmd.clear_run = 1'b1;
				if (sts.clear_done)
					state_d = bba_pkg::S_IDLE;
			end
			bba_pkg::S_RECOUNT: begin
				// restart when the pool size changed again
				if (sts.recount_pend)
					cmd.recount_start = 1'b1;
				else begin
					cmd.recount_run = 1'b1;
					if (sts.recount_done)
						state_d = bba_pkg::S_IDLE;
				end
			end
			bba_pkg::S_IDLE: begin
				if (start && !busy) begin
					cmd.accept = 1'b1;
					state_d    = bba_pkg::S_DIVIDE;
				end else if (sts.recount_pend) begin
					cmd.recount_start = 1'b1;
					state_d           = bba_pkg::S_RECOUNT;
				end
			end
			bba_pkg::S_DIVIDE: begin
				if (sts.div_done)
					state_d = bba_pkg::S_CHECK;
			end
			bba_pkg::S_CHECK: begin
				if (sts.reject_size) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = bba_pkg::ST_TOO_MANY;
					state_d      = bba_pkg::S_IDLE;
				end else if (sts.reject_free) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = bba_pkg::ST_NO_SPACE;
					state_d      = bba_pkg::S_IDLE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = bba_pkg::S_SCAN;
				end
			end
			bba_pkg::S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done)
					state_d = bba_pkg::S_IDLE;
			end
			default: begin
				state_d = bba_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/bitmap_block_allocator.sv @@
// Top level of the bitmap first-fit block allocator.
// Joins bba_ctrl and bba_datapath; depends on bba_pkg.
//
//  channel   | ports                                            | handshake
//  ----------+--------------------------------------------------+---------------------------
//  request   | start, busy, request_bytes                       | taken when start & !busy
//  result    | result_valid, block_number, is_index_block,      | one-cycle strobe, no stall
//            | status, last, free_count                         |
//  config    | cfg_we, cfg_index, cfg_wdata                     | written when cfg_we
//
// A request takes its accept cycle, the serial divider (17 quotient bits, then a done
// strobe), the check state, then a scan of the bitmap memory, one block per cycle.
// Rejected requests finish after the check.
// After reset a clearing pass zeroes the bitmap with busy high.
// A pool size write starts a recount sweep, busy high.
// Results leave on a strobe in the cycle after each pick; the receiver cannot stall them.
module bitmap_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bba_pkg::REQ_W-1:0]     request_bytes,
	input  logic                          cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::CNT_W-1:0]     cfg_wdata,
	output logic                          result_valid,
	output logic [bba_pkg::BN_W-1:0]      block_number,
	output logic                          is_index_block,
	output logic [1:0]                    status,
	output logic                          last,
	output logic [bba_pkg::CNT_W-1:0]     free_count
);

	bba_pkg::cmd_t cmd;
	bba_pkg::sts_t sts;

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bba_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.request_bytes  (request_bytes),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.result_valid   (result_valid),
		.block_number   (block_number),
		.is_index_block (is_index_block),
		.status         (status),
		.last           (last),
		.free_count     (free_count)
	);

endmodule
